FILE: hdl/semijoin_group_sum_aggregator_unit_macros.svh
// assertion helpers for the aggregator
`ifndef SEMIJOIN_GROUP_SUM_AGGREGATOR_UNIT_MACROS_SVH
`define SEMIJOIN_GROUP_SUM_AGGREGATOR_UNIT_MACROS_SVH

// checked only outside reset
`define SGSA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SGSA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/sgsa_pkg.sv
`default_nettype none

package sgsa_pkg;

   // default size of the supplier membership bitmap
   localparam int SGSA_SUPPLIER_KEYS = 65536;

   // supplier keys that the 16-bit field can carry
   localparam int SGSA_KEY_SPACE = 65536;

   // bitmap bits kept in one memory row
   localparam int SGSA_ROW_BITS = 32;
   localparam int SGSA_ROW_SEL_W = 5;

   // result queue
   localparam int SGSA_QUEUE_DEPTH = 8;

   // item kinds
   typedef enum logic [1:0] {
      MODE_SUPPLIER = 2'd0,
      MODE_PARTSUPP = 2'd1,
      MODE_END      = 2'd2
   } mode_type;

   // one result word
   typedef struct packed {
      logic [30:0] part_key;
      logic [63:0] group_sum;
      logic [63:0] grand_total;
      logic        is_total;
      logic        last;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: hdl/semijoin_group_sum_aggregator_unit.sv
// Semi-join bitmap filter with group-by sum.
// Request channel (req_valid/req_stall): one word per item, mode selects a
// supplier row, a partsupp row or an end-of-stream flush. Response channel
// (rsp_valid/rsp_stall): group results and the final total, in order.
// csr_write_enable/csr_write_data set the admitted nation key; the user
// writes it only while idle, as the block itself does not enforce this.
// Throughput: one item per cycle while req_stall is low; the bitmap row
// for an item is read from a synchronous RAM with one read and one write
// port at accept and updated in the next cycle, with a forwarding register
// covering back-to-back rows that hit the same word. Stage one pushes the
// results into the queue; an end item pushes up to two in the same cycle.
// Responses wait in an 8-entry queue; req_stall rises when the queue could
// not hold the worst case of the item in flight plus one more, so a stalled
// receiver backs up into the request side without losing a word.
// Reset: group key, group sum, total and nation key go to zero, and a
// clearing pass writes every bitmap row to zero, one 32-bit row per cycle,
// over ceil(min(SUPPLIER_KEYS, 65536) / 32) rows (2048 by default), with
// req_stall held high throughout.

`default_nettype none

`include "semijoin_group_sum_aggregator_unit_macros.svh"

module semijoin_group_sum_aggregator_unit
   import sgsa_pkg::*;
#(
   parameter int SUPPLIER_KEYS = SGSA_SUPPLIER_KEYS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [15:0] req_supplier_key,
   input  wire logic [7:0]  req_supplier_nation,
   input  wire logic [30:0] req_part_key,
   input  wire logic signed [31:0] req_row_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [30:0]      rsp_group_part_key,
   output logic signed [63:0] rsp_group_sum,
   output logic signed [63:0] rsp_grand_total,
   output logic             rsp_is_total,
   output logic             rsp_last
);

   localparam int EFF_KEYS = (SUPPLIER_KEYS < SGSA_KEY_SPACE) ? SUPPLIER_KEYS : SGSA_KEY_SPACE;
   localparam int ROWS = (EFF_KEYS + SGSA_ROW_BITS - 1) / SGSA_ROW_BITS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int QPTR_W = $clog2(SGSA_QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // configuration
   logic [7:0] admit_nation_ff;

   // clearing pass
   logic             clr_active_ff;
   logic [ROW_W-1:0] clr_row_ff;

   // stage one
   logic                    s1_valid_ff;
   logic [1:0]              s1_mode_ff;
   logic [15:0]             s1_key_ff;
   logic                    s1_match_ff;
   logic                    s1_range_ff;
   logic [30:0]             s1_part_key_ff;
   logic signed [31:0]      s1_value_ff;

   // bitmap memory
   logic [SGSA_ROW_BITS-1:0] bitmap_mem [ROWS];
   logic [SGSA_ROW_BITS-1:0] rd_data_ff;
   logic                     fwd_hit_ff;
   logic [SGSA_ROW_BITS-1:0] fwd_data_ff;

   // group state
   logic [30:0] group_key_ff;
   logic [63:0] group_sum_ff;
   logic [63:0] total_ff;
   logic [30:0] group_key_in;
   logic [63:0] group_sum_in;
   logic [63:0] total_in;

   // result queue
   rsp_word_type              queue_mem [SGSA_QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff;
   logic [QPTR_W-1:0]         rd_ptr_ff;
   logic [QCNT_W-1:0]         count_ff;

   logic                     req_accept;
   logic                     rsp_accept;
   logic [ROW_W-1:0]         req_row;
   logic [ROW_W-1:0]         s1_row;
   logic                     req_in_range;
   logic [SGSA_ROW_BITS-1:0] row_data;
   logic                     admitted;
   logic                     s1_wr_en;
   logic [SGSA_ROW_BITS-1:0] s1_wr_data;
   logic                     mem_wr_en;
   logic [ROW_W-1:0]         mem_wr_addr;
   logic [SGSA_ROW_BITS-1:0] mem_wr_data;
   logic [63:0]              value_ext;
   logic [63:0]              add_value;
   logic                     push0;
   logic                     push1;
   rsp_word_type             push0_word;
   rsp_word_type             push1_word;
   logic [QCNT_W-1:0]        reserve;
   rsp_word_type             head_word;

   // handshakes and flow control
   assign reserve = QCNT_W'(s1_valid_ff ? 4 : 2);
   assign req_stall = clr_active_ff
      || ((count_ff + reserve) > QCNT_W'(SGSA_QUEUE_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;

   // row addressing
   assign req_row = ROW_W'(req_supplier_key >> SGSA_ROW_SEL_W);
   assign s1_row = ROW_W'(s1_key_ff >> SGSA_ROW_SEL_W);
   assign req_in_range = ({1'b0, req_supplier_key} < 17'(EFF_KEYS));

   // membership lookup and set, with forwarding of the previous write
   assign row_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign admitted = s1_range_ff && row_data[s1_key_ff[SGSA_ROW_SEL_W-1:0]];
   assign s1_wr_en = s1_valid_ff && (s1_mode_ff == MODE_SUPPLIER)
      && s1_match_ff && s1_range_ff;
   assign s1_wr_data = row_data
      | (SGSA_ROW_BITS'(1) << s1_key_ff[SGSA_ROW_SEL_W-1:0]);

   // memory write port: clearing pass or row update
   always_comb begin
      if (clr_active_ff) begin
         mem_wr_en = 1'b1;
         mem_wr_addr = clr_row_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en = s1_wr_en;
         mem_wr_addr = s1_row;
         mem_wr_data = s1_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         bitmap_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (req_accept) begin
         rd_data_ff <= bitmap_mem[req_row];
      end
   end

   // group arithmetic and result words
   assign value_ext = {{32{s1_value_ff[31]}}, s1_value_ff};
   assign add_value = admitted ? value_ext : 64'd0;

   always_comb begin
      group_key_in = group_key_ff;
      group_sum_in = group_sum_ff;
      total_in = total_ff;
      push0 = 1'b0;
      push1 = 1'b0;
      push0_word = '{part_key: group_key_ff, group_sum: group_sum_ff,
                     grand_total: total_ff, is_total: 1'b0, last: 1'b1};
      push1_word = '{part_key: 31'd0, group_sum: 64'd0,
                     grand_total: total_ff, is_total: 1'b1, last: 1'b1};
      if (s1_valid_ff) begin
         case (s1_mode_ff)
            MODE_PARTSUPP: begin
               total_in = total_ff + add_value;
               if (s1_part_key_ff != group_key_ff) begin
                  push0 = (group_sum_ff != 64'd0);
                  group_key_in = s1_part_key_ff;
                  group_sum_in = add_value;
               end else begin
                  group_sum_in = group_sum_ff + add_value;
               end
            end
            MODE_END: begin
               if (group_sum_ff != 64'd0) begin
                  push0 = 1'b1;
                  push1 = 1'b1;
                  push0_word.last = 1'b0;
               end else begin
                  push0 = 1'b1;
                  push0_word = push1_word;
               end
               group_key_in = 31'd0;
               group_sum_in = 64'd0;
               total_in = 64'd0;
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         admit_nation_ff <= 8'd0;
         clr_active_ff <= 1'b1;
         clr_row_ff <= '0;
         s1_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         group_key_ff <= 31'd0;
         group_sum_ff <= 64'd0;
         total_ff <= 64'd0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            admit_nation_ff <= csr_write_data;
         end
         if (clr_active_ff) begin
            clr_row_ff <= clr_row_ff + ROW_W'(1);
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
         s1_valid_ff <= req_accept;
         fwd_hit_ff <= req_accept && s1_wr_en && (s1_row == req_row);
         group_key_ff <= group_key_in;
         group_sum_ff <= group_sum_in;
         total_ff <= total_in;
         wr_ptr_ff <= wr_ptr_ff + QPTR_W'(push0) + QPTR_W'(push1);
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push0) + QCNT_W'(push1)
            - QCNT_W'(rsp_accept);
      end
   end

   // stage one payload and forwarded row
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff <= req_mode;
         s1_key_ff <= req_supplier_key;
         s1_match_ff <= (req_supplier_nation == admit_nation_ff);
         s1_range_ff <= req_in_range;
         s1_part_key_ff <= req_part_key;
         s1_value_ff <= req_row_value;
      end
      fwd_data_ff <= s1_wr_data;
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push0) begin
         queue_mem[wr_ptr_ff] <= push0_word;
      end
      if (push1) begin
         queue_mem[wr_ptr_ff + QPTR_W'(1)] <= push1_word;
      end
   end

   // response outputs
   assign head_word = queue_mem[rd_ptr_ff];
   assign rsp_group_part_key = head_word.part_key;
   assign rsp_group_sum = head_word.group_sum;
   assign rsp_grand_total = head_word.grand_total;
   assign rsp_is_total = head_word.is_total;
   assign rsp_last = head_word.last;

   // checks
   `SGSA_ASSERT(a_queue_bound, count_ff <= QCNT_W'(SGSA_QUEUE_DEPTH), "result queue overflow")
   `SGSA_ASSERT_ALWAYS(a_no_accept_clear, req_accept |-> !clr_active_ff, "item taken during clearing pass")
   `SGSA_ASSERT(a_end_clears, (s1_valid_ff && s1_mode_ff == MODE_END) |=> (total_ff == 64'd0 && group_sum_ff == 64'd0), "end item left state behind")
   `SGSA_ASSERT(a_fwd_source, fwd_hit_ff |-> $past(s1_wr_en), "forwarding without a row write")

endmodule

`default_nettype wire

FILE: tb/semijoin_group_sum_checker.sv
module semijoin_group_sum_checker
   import sgsa_pkg::*;
#(
   parameter int SUPPLIER_KEYS = SGSA_SUPPLIER_KEYS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [15:0]        req_supplier_key,
   input  logic [7:0]         req_supplier_nation,
   input  logic [30:0]        req_part_key,
   input  logic signed [31:0] req_row_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [30:0]        rsp_group_part_key,
   input  logic signed [63:0] rsp_group_sum,
   input  logic signed [63:0] rsp_grand_total,
   input  logic               rsp_is_total,
   input  logic               rsp_last,
   output int                 mismatch_count,
   output int                 pending_results,
   output int                 results_checked,
   output int                 totals_checked
);

   // shadow copy of the block state
   bit           member_bits [SGSA_KEY_SPACE];
   logic [7:0]   admit_nation;
   logic [30:0]  group_key;
   logic [63:0]  group_sum;
   logic [63:0]  running_total;
   rsp_word_type expected_results [$];

   function automatic rsp_word_type make_word(input logic [30:0] key, input logic [63:0] gsum,
                                              input logic [63:0] total, input logic is_tot,
                                              input logic is_last);
      rsp_word_type w;
      w.part_key    = key;
      w.group_sum   = gsum;
      w.grand_total = total;
      w.is_total    = is_tot;
      w.last        = is_last;
      return w;
   endfunction

   // append one word to the expected results
   task automatic add_expected(input rsp_word_type w);
      expected_results = {expected_results, w};
   endtask

   // advance the shadow state by one request word and queue its result words
   task automatic predict_word(input logic [1:0] mode, input logic [15:0] skey,
                               input logic [7:0] snat, input logic [30:0] pkey,
                               input logic [31:0] val);
      logic [63:0] wide;
      bit          admitted;
      wide     = {{32{val[31]}}, val};
      admitted = (int'(skey) < SUPPLIER_KEYS) && member_bits[skey];
      case (mode)
         MODE_SUPPLIER: begin
            if (snat == admit_nation && int'(skey) < SUPPLIER_KEYS)
               member_bits[skey] = 1'b1;
         end
         MODE_PARTSUPP: begin
            // key change closes the open group, emitted only when nonzero
            if (pkey != group_key) begin
               if (group_sum != 64'd0)
                  add_expected(make_word(group_key, group_sum, running_total, 1'b0, 1'b1));
               group_key = pkey;
               group_sum = 64'd0;
            end
            if (admitted) begin
               running_total = running_total + wide;
               group_sum     = group_sum + wide;
            end
         end
         MODE_END: begin
            // flush pending group, then the total, then start over
            if (group_sum != 64'd0)
               add_expected(make_word(group_key, group_sum, running_total, 1'b0, 1'b0));
            add_expected(make_word('0, '0, running_total, 1'b1, 1'b1));
            group_key     = '0;
            group_sum     = '0;
            running_total = '0;
         end
         default: ;
      endcase
   endtask

   function automatic int field_mismatch(input string name, input logic [63:0] exp_v,
                                         input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%h, got 0x%h", name, exp_v, act_v);
         return 1;
      end
      return 0;
   endfunction

   // watch both channels and the register port at each rising edge
   always @(posedge clock) begin : watch
      rsp_word_type want;
      int           bad;
      if (reset) begin
         foreach (member_bits[i]) member_bits[i] = 1'b0;
         admit_nation  = '0;
         group_key     = '0;
         group_sum     = '0;
         running_total = '0;
         expected_results.delete();
      end else begin
         if (csr_write_enable)
            admit_nation = csr_write_data;
         if (req_valid && !req_stall)
            predict_word(req_mode, req_supplier_key, req_supplier_nation, req_part_key,
                         req_row_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result word: key 0x%h sum 0x%h total 0x%h",
                      rsp_group_part_key, rsp_group_sum, rsp_grand_total);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               bad  = field_mismatch("group_part_key", 64'(want.part_key),
                                     64'(rsp_group_part_key));
               bad += field_mismatch("group_sum", want.group_sum, rsp_group_sum);
               bad += field_mismatch("grand_total", want.grand_total, rsp_grand_total);
               bad += field_mismatch("is_total", 64'(want.is_total), 64'(rsp_is_total));
               bad += field_mismatch("last", 64'(want.last), 64'(rsp_last));
               mismatch_count += bad;
               results_checked++;
               if (want.is_total)
                  totals_checked++;
            end
         end
      end
      pending_results = expected_results.size();
   end

endmodule

FILE: tb/semijoin_group_sum_aggregator_unit_tb.sv
module semijoin_group_sum_aggregator_unit_tb
   import sgsa_pkg::*;
();

   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int         HOLD_CYCLES   = 200;
   localparam int         DRAIN_LIMIT   = 20000;
   localparam int         SETTLE_CYCLES = 6;
   localparam int         TIMEOUT       = 4000000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [7:0]         csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_mode;
   logic [15:0]        req_supplier_key;
   logic [7:0]         req_supplier_nation;
   logic [30:0]        req_part_key;
   logic signed [31:0] req_row_value;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [30:0]        rsp_group_part_key;
   logic signed [63:0] rsp_group_sum;
   logic signed [63:0] rsp_grand_total;
   logic               rsp_is_total;
   logic               rsp_last;

   int          mismatch_count;
   int          pending_results;
   int          results_checked;
   int          totals_checked;
   int          words_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          failures;
   logic [7:0]  nation_setting;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   semijoin_group_sum_aggregator_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_supplier_key    (req_supplier_key),
      .req_supplier_nation (req_supplier_nation),
      .req_part_key        (req_part_key),
      .req_row_value       (req_row_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_group_part_key  (rsp_group_part_key),
      .rsp_group_sum       (rsp_group_sum),
      .rsp_grand_total     (rsp_grand_total),
      .rsp_is_total        (rsp_is_total),
      .rsp_last            (rsp_last)
   );

   semijoin_group_sum_checker i_checker (.*);

   // receiver: random stalls, or a long counted hold-off when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // run limit
   initial begin
      #(TIMEOUT);
      $display("== FAIL ==");
      $finish;
   end

   // offer one word, with random idle cycles ahead of it, and hold until taken
   task automatic send_word(input logic [1:0] mode, input logic [15:0] skey,
                            input logic [7:0] snat, input logic [30:0] pkey,
                            input logic [31:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_mode            <= mode;
      req_supplier_key    <= skey;
      req_supplier_nation <= snat;
      req_part_key        <= pkey;
      req_row_value       <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (mode != MODE_UNUSED)
         words_sent++;
   endtask

   // stop sending and let every expected result word come back
   task automatic wait_drained();
      int spins;
      spins = 0;
      req_valid <= 1'b0;
      while (pending_results != 0 && spins < DRAIN_LIMIT) begin
         @(negedge clock);
         spins++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_nation(input logic [7:0] value);
      nation_setting = value;
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // supplier keys mostly from a small pool so that rows hit the bitmap
   function automatic logic [15:0] pick_supplier();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hffff;
         2:       return 16'($urandom_range(65535));
         default: return 16'($urandom_range(1023));
      endcase
   endfunction

   function automatic logic [30:0] pick_part_key();
      case ($urandom_range(7))
         0:       return 31'd0;
         1:       return 31'h7fff_ffff;
         2, 3:    return 31'($urandom_range(15));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3:    return 32'($urandom_range(32)) - 32'd16;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed streams: supplier rows, grouped partsupp rows, end word
   task automatic run_streams(input int quota);
      int          target;
      int          n_rows;
      logic [30:0] pkey;
      logic [31:0] val;
      logic [31:0] prev;
      logic [15:0] skey;
      target = words_sent + quota;
      while (words_sent < target) begin
         if ($urandom_range(9) == 0) begin
            // noise word of any kind, unused mode included
            send_word(2'($urandom_range(3)), 16'($urandom), 8'($urandom), 31'($urandom),
                      $urandom);
         end else begin
            repeat ($urandom_range(4))
               send_word(MODE_SUPPLIER, pick_supplier(),
                         ($urandom_range(9) < 6) ? nation_setting : 8'($urandom),
                         31'($urandom), $urandom);
            repeat ($urandom_range(1, 4)) begin
               pkey   = pick_part_key();
               n_rows = $urandom_range(1, 4);
               prev   = '0;
               skey   = pick_supplier();
               repeat (n_rows) begin
                  // negated repeat of the previous row often cancels the group to zero
                  if ($urandom_range(3) == 0) begin
                     val = -prev;
                  end else begin
                     val  = pick_value();
                     skey = pick_supplier();
                  end
                  send_word(MODE_PARTSUPP, skey, 8'($urandom), pkey, val);
                  prev = val;
               end
            end
            if ($urandom_range(9) < 7)
               send_word(MODE_END, pick_supplier(), 8'($urandom), 31'($urandom), $urandom);
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_valid           = 1'b0;
      req_mode            = MODE_SUPPLIER;
      req_supplier_key    = '0;
      req_supplier_nation = '0;
      req_part_key        = '0;
      req_row_value       = '0;
      nation_setting      = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words, nation key at its low extreme
      write_nation(8'd0);
      send_idle_pct  = 37;
      recv_stall_pct = 48;
      send_word(MODE_SUPPLIER, 16'h0000, 8'd0, 31'd0, 32'd0);
      send_word(MODE_SUPPLIER, 16'hffff, 8'd0, 31'h7fff_ffff, 32'hffff_ffff);
      send_word(MODE_SUPPLIER, 16'd100, 8'd255, 31'd0, 32'd0);
      send_word(MODE_UNUSED, 16'hffff, 8'd255, 31'h7fff_ffff, 32'hffff_ffff);
      // first group keeps key zero, so no flush on the first row
      send_word(MODE_PARTSUPP, 16'h0000, 8'd255, 31'd0, 32'h7fff_ffff);
      send_word(MODE_PARTSUPP, 16'hffff, 8'd0, 31'd0, 32'h8000_0000);
      send_word(MODE_PARTSUPP, 16'd100, 8'd0, 31'd0, 32'd5);
      send_word(MODE_PARTSUPP, 16'h0000, 8'd0, 31'h7fff_ffff, 32'd7);
      // group that nets to zero is dropped
      send_word(MODE_PARTSUPP, 16'h0000, 8'd0, 31'h7fff_ffff, -32'sd7);
      send_word(MODE_PARTSUPP, 16'h0000, 8'd0, 31'd5, 32'd3);
      send_word(MODE_END, 16'd0, 8'd0, 31'd0, 32'd0);
      // end with nothing pending reports only the total
      send_word(MODE_END, 16'hffff, 8'd255, 31'h7fff_ffff, 32'hffff_ffff);
      send_word(MODE_PARTSUPP, 16'hffff, 8'd0, 31'd9, 32'hffff_ffff);
      send_word(MODE_PARTSUPP, 16'h1234, 8'd0, 31'd9, 32'h8000_0000);
      send_word(MODE_PARTSUPP, 16'hffff, 8'd0, 31'd10, 32'h8000_0000);
      send_word(MODE_PARTSUPP, 16'hffff, 8'd0, 31'd10, 32'h8000_0000);
      send_word(MODE_END, 16'd0, 8'd0, 31'd0, 32'd0);
      wait_drained();

      // receiver stalls more than sender idles, nation key at its high extreme
      write_nation(8'd255);
      run_streams(80);
      hold_requests++;
      run_streams(120);
      wait_drained();

      // sender idles more than receiver stalls
      write_nation(8'($urandom_range(1, 254)));
      send_idle_pct  = 48;
      recv_stall_pct = 37;
      run_streams(200);
      wait_drained();

      // back to back with a mid-phase pause and a second hold-off
      write_nation(8'($urandom_range(255)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_streams(100);
      wait_drained();
      hold_requests++;
      run_streams(100);
      wait_drained();

      if (pending_results != 0)
         $error("%0d expected result words never arrived", pending_results);
      failures = mismatch_count + pending_results;
      $display("covered %0d request words and %0d result words, %0d of them totals,",
               words_sent, results_checked, totals_checked);
      $display("over four nation keys, random stalls on both sides and two long hold-offs");
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: semijoin_group_sum_aggregator_unit.f
+incdir+hdl
hdl/sgsa_pkg.sv
hdl/semijoin_group_sum_aggregator_unit.sv
tb/semijoin_group_sum_checker.sv
tb/semijoin_group_sum_aggregator_unit_tb.sv
